// ===== rtl/wfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared constants, types and control structs for the winnowing selector.
// ----------------------------------------------------------------------------
package wfs_pkg;

    localparam int WINDOW_MAX = 8;
    localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int POS_W      = $clog2(WINDOW_MAX + 1);
    localparam int HASH_W     = 63;
    localparam int LINE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int WSZ_W      = 4;

    localparam logic [WSZ_W-1:0] WSZ_RESET = 4'd4;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } wfs_state_t;

    typedef struct packed {
        logic load;
        logic scan_load;
        logic scan_step;
        logic take_new;
        logic emit_load;
        logic finish;
    } wfs_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic take_new;
        logic scan_done;
        logic out_free;
    } wfs_stat_t;

endpackage

// ===== rtl/wfs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfs_dpath
// Window shift register, running minimum, serial rescan unit, counters and
// output register.
// ----------------------------------------------------------------------------
module wfs_dpath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  wfs_pkg::wfs_cmd_t         cmd,
    output wfs_pkg::wfs_stat_t        stat,
    input  logic                      cfg_we,
    input  logic [wfs_pkg::WSZ_W-1:0] cfg_wdata,
    input  logic [wfs_pkg::HASH_W-1:0] s_hash_value,
    input  logic [wfs_pkg::LINE_W-1:0] s_start_line,
    input  logic [wfs_pkg::LINE_W-1:0] s_end_line,
    input  logic                      s_stream_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [wfs_pkg::HASH_W-1:0] m_picked_hash,
    output logic [wfs_pkg::LINE_W-1:0] m_picked_start_line,
    output logic [wfs_pkg::LINE_W-1:0] m_picked_end_line,
    output logic [wfs_pkg::CNT_W-1:0]  m_selection_count
);
    import wfs_pkg::*;

    logic [HASH_W-1:0] hash_reg [WINDOW_MAX];
    logic [LINE_W-1:0] sl_reg   [WINDOW_MAX];
    logic [LINE_W-1:0] el_reg   [WINDOW_MAX];

    logic [WSZ_W-1:0]  wsize_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  seen_reg;
    logic              pos_valid_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [HASH_W-1:0] min_hash_reg;
    logic [LINE_W-1:0] min_sl_reg;
    logic [LINE_W-1:0] min_el_reg;
    logic [AGE_W-1:0]  idx_reg;
    logic              first_reg;

    logic              m_valid_reg;
    logic [HASH_W-1:0] out_hash_reg;
    logic [LINE_W-1:0] out_sl_reg;
    logic [LINE_W-1:0] out_el_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic [POS_W-1:0]  eff_win;
    logic              full;
    logic [POS_W-1:0]  scan_cnt;
    logic [CNT_W-1:0]  total_next;
    logic [POS_W-1:0]  pos_inc;
    logic              scan_take;

    always_comb begin
        if (wsize_reg == '0) begin
            eff_win = POS_W'(1);
        end else if (32'(wsize_reg) > WINDOW_MAX) begin
            eff_win = POS_W'(WINDOW_MAX);
        end else begin
            eff_win = POS_W'(wsize_reg);
        end
    end

    assign full     = seen_reg >= CNT_W'(eff_win);
    assign scan_cnt = full ? eff_win : seen_reg[POS_W-1:0];
    assign pos_inc  = (32'(pos_reg) >= WINDOW_MAX) ? POS_W'(WINDOW_MAX) : pos_reg + 1'b1;
    assign total_next = (total_reg == CNT_MAX) ? total_reg : total_reg + 1'b1;
    assign scan_take  = first_reg || (hash_reg[idx_reg] < min_hash_reg);

    always_comb begin
        stat.need_scan = full ? (!pos_valid_reg || pos_reg >= eff_win) : last_reg;
        stat.take_new  = full && pos_valid_reg && (pos_reg < eff_win) &&
                         (hash_reg[0] <= min_hash_reg);
        stat.scan_done = idx_reg == '0;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // window storage, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int a = WINDOW_MAX - 1; a > 0; a--) begin
                hash_reg[a] <= hash_reg[a-1];
                sl_reg[a]   <= sl_reg[a-1];
                el_reg[a]   <= el_reg[a-1];
            end
            hash_reg[0] <= s_hash_value;
            sl_reg[0]   <= s_start_line;
            el_reg[0]   <= s_end_line;
        end
    end

    // minimum payload and output payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            last_reg <= s_stream_end;
        end
        if (cmd.scan_load) begin
            idx_reg   <= AGE_W'(scan_cnt - 1'b1);
            first_reg <= 1'b1;
        end
        if (cmd.scan_step) begin
            first_reg <= 1'b0;
            idx_reg   <= idx_reg - 1'b1;
            if (scan_take) begin
                min_hash_reg <= hash_reg[idx_reg];
                min_sl_reg   <= sl_reg[idx_reg];
                min_el_reg   <= el_reg[idx_reg];
            end
        end
        if (cmd.take_new) begin
            min_hash_reg <= hash_reg[0];
            min_sl_reg   <= sl_reg[0];
            min_el_reg   <= el_reg[0];
        end
        if (cmd.emit_load) begin
            out_hash_reg <= min_hash_reg;
            out_sl_reg   <= min_sl_reg;
            out_el_reg   <= min_el_reg;
            out_cnt_reg  <= total_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg     <= WSZ_RESET;
            seen_reg      <= '0;
            pos_valid_reg <= 1'b0;
            pos_reg       <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                wsize_reg <= cfg_wdata;
            end
            if (cmd.emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                if (seen_reg != CNT_MAX) begin
                    seen_reg <= seen_reg + 1'b1;
                end
                if (pos_valid_reg) begin
                    pos_reg <= pos_inc;
                end
            end
            if (cmd.scan_step && scan_take) begin
                pos_valid_reg <= 1'b1;
                pos_reg       <= POS_W'(idx_reg);
            end
            if (cmd.take_new) begin
                pos_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            // end of stream: back to an empty stream
            if (cmd.finish && last_reg) begin
                seen_reg      <= '0;
                pos_valid_reg <= 1'b0;
                total_reg     <= '0;
            end else if (cmd.emit_load) begin
                total_reg <= total_next;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_picked_hash       = out_hash_reg;
    assign m_picked_start_line = out_sl_reg;
    assign m_picked_end_line   = out_el_reg;
    assign m_selection_count   = out_cnt_reg;

endmodule

// ===== rtl/wfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfs_ctrl
// Sequencer: take item, decide, rescan window, emit selection.
// ----------------------------------------------------------------------------
module wfs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wfs_pkg::wfs_stat_t stat,
    output wfs_pkg::wfs_cmd_t  cmd
);
    import wfs_pkg::*;

    wfs_state_t state_reg;
    wfs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.need_scan) begin
                    state_next = ST_SCAN;
                end else if (stat.take_new) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DECIDE: begin
                if (stat.need_scan) begin
                    cmd.scan_load = 1'b1;
                end else if (stat.take_new) begin
                    cmd.take_new = 1'b1;
                end else begin
                    cmd.finish = 1'b1;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit_load = stat.out_free;
                cmd.finish    = stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/winnowing_fingerprint_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winnowing_fingerprint_select
// Winnowing fingerprint selection over a sliding window of k-gram hashes.
// ----------------------------------------------------------------------------
//   channel | ports                      | direction | handshake
//   s_      | hash, start/end line, end  | in        | s_valid / s_ready
//   m_      | hash, line range, count    | out       | m_valid / m_ready
//   cfg_    | window size                | in        | cfg_we, no wait
//
// One item at a time: load, then decide; then an emit step when the new hash
// takes the minimum, or a rescan of at most 8 window entries and then the emit
// step; the rescan compares one entry per cycle.
// Reset (aresetn, synchronous) empties the stream; window size returns to 4.
// A held result stalls the emit step, and no new item enters until that step is done.
// ----------------------------------------------------------------------------
module winnowing_fingerprint_select (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [wfs_pkg::WSZ_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wfs_pkg::HASH_W-1:0]  s_hash_value,
    input  logic [wfs_pkg::LINE_W-1:0]  s_start_line,
    input  logic [wfs_pkg::LINE_W-1:0]  s_end_line,
    input  logic                        s_stream_end,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [wfs_pkg::HASH_W-1:0]  m_picked_hash,
    output logic [wfs_pkg::LINE_W-1:0]  m_picked_start_line,
    output logic [wfs_pkg::LINE_W-1:0]  m_picked_end_line,
    output logic [wfs_pkg::CNT_W-1:0]   m_selection_count
);
    import wfs_pkg::*;

    wfs_cmd_t  cmd;
    wfs_stat_t stat;

    wfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wfs_dpath u_dpath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_hash_value        (s_hash_value),
        .s_start_line        (s_start_line),
        .s_end_line          (s_end_line),
        .s_stream_end        (s_stream_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_picked_hash       (m_picked_hash),
        .m_picked_start_line (m_picked_start_line),
        .m_picked_end_line   (m_picked_end_line),
        .m_selection_count   (m_selection_count)
    );

`ifndef NO_ASSERTIONS
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_selection_count != '0)
        else $error("selection with zero count");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item taken while busy");

    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> (!m_valid || m_ready))
        else $error("result overwritten");
`endif

endmodule

// ===== bench/wfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winnowing_pick_checker
// Watches the item, result and window-size ports of the winnowing selector.
// Each accepted item goes through a local copy of the window, the minimum
// tracking and the per-stream counts. Each expected fingerprint is queued,
// and every result item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module winnowing_pick_checker
    import wfs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [WSZ_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [HASH_W-1:0] s_hash_value,
    input  logic [LINE_W-1:0] s_start_line,
    input  logic [LINE_W-1:0] s_end_line,
    input  logic              s_stream_end,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [HASH_W-1:0] m_picked_hash,
    input  logic [LINE_W-1:0] m_picked_start_line,
    input  logic [LINE_W-1:0] m_picked_end_line,
    input  logic [CNT_W-1:0]  m_selection_count,
    output int                fail_count,
    output int                pending_count,
    output int                results_checked
);

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [LINE_W-1:0] first_line;
        logic [LINE_W-1:0] last_line;
        logic [CNT_W-1:0]  count;
    } pick_t;

    // index is age, 0 = newest
    logic [HASH_W-1:0] win_hash  [WINDOW_MAX];
    logic [LINE_W-1:0] win_first [WINDOW_MAX];
    logic [LINE_W-1:0] win_last  [WINDOW_MAX];
    int unsigned       stream_items;
    int unsigned       min_age;
    bit                min_held;
    logic [CNT_W-1:0]  stream_picks;
    logic [WSZ_W-1:0]  window_reg;
    pick_t             pick_queue [$];

    // oldest entry wins among equal hashes
    function automatic int unsigned oldest_min(int unsigned n);
        int unsigned best;
        int unsigned a;
        best = n - 1;
        a = best;
        while (a > 0) begin
            a--;
            if (win_hash[a] < win_hash[best]) best = a;
        end
        return best;
    endfunction

    function automatic void winnow_step(logic [HASH_W-1:0] h, logic [LINE_W-1:0] fl,
                                        logic [LINE_W-1:0] ll, logic last);
        int unsigned span;
        int unsigned a;
        bit          fire;
        pick_t       next_pick;
        if (window_reg == 0) span = 1;
        else if (window_reg > WINDOW_MAX) span = WINDOW_MAX;
        else span = window_reg;

        a = WINDOW_MAX - 1;
        while (a > 0) begin
            win_hash[a]  = win_hash[a-1];
            win_first[a] = win_first[a-1];
            win_last[a]  = win_last[a-1];
            a--;
        end
        win_hash[0]  = h;
        win_first[0] = fl;
        win_last[0]  = ll;

        if (min_held && min_age < WINDOW_MAX) min_age++;
        if (stream_items < CNT_MAX) stream_items++;

        fire = 1'b0;
        if (stream_items >= span) begin
            if (!min_held || min_age >= span) begin
                min_age  = oldest_min(span);
                min_held = 1'b1;
                fire     = 1'b1;
            end else if (win_hash[0] <= win_hash[min_age]) begin
                min_age = 0;
                fire    = 1'b1;
            end
        end else if (last) begin
            // short stream: pick over everything seen
            min_age  = oldest_min(stream_items);
            min_held = 1'b1;
            fire     = 1'b1;
        end

        if (fire) begin
            if (stream_picks != CNT_MAX) stream_picks++;
            next_pick = '{win_hash[min_age], win_first[min_age],
                          win_last[min_age], stream_picks};
            pick_queue.insert(pick_queue.size(), next_pick);
        end

        if (last) begin
            stream_items = 0;
            min_held     = 1'b0;
            stream_picks = '0;
        end
    endfunction

    always @(posedge aclk) begin
        pick_t got;
        pick_t exp_pick;
        if (!aresetn) begin
            stream_items = 0;
            min_held     = 1'b0;
            min_age      = 0;
            stream_picks = '0;
            window_reg   = WSZ_RESET;
            pick_queue.delete();
        end else begin
            if (cfg_we) window_reg = cfg_wdata;
            if (m_valid && m_ready) begin
                got = '{m_picked_hash, m_picked_start_line, m_picked_end_line,
                        m_selection_count};
                results_checked++;
                if (pick_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: hash %h lines %0d..%0d count %0d",
                                 got.hash, got.first_line, got.last_line, got.count);
                end else begin
                    exp_pick = pick_queue.pop_front();
                    if (got.hash !== exp_pick.hash || got.first_line !== exp_pick.first_line ||
                        got.last_line !== exp_pick.last_line || got.count !== exp_pick.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch on result %0d: expected hash %h lines %0d..%0d count %0d",
                                     results_checked, exp_pick.hash, exp_pick.first_line,
                                     exp_pick.last_line, exp_pick.count);
                            $display("                      actual hash %h lines %0d..%0d count %0d",
                                     got.hash, got.first_line, got.last_line, got.count);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                winnow_step(s_hash_value, s_start_line, s_end_line, s_stream_end);
        end
        pending_count = pick_queue.size();
    end

endmodule

// ===== bench/winnowing_fingerprint_select_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winnowing_fingerprint_select_tb
// Drives k-gram hash streams into the winnowing selector: a short directed
// set (field extremes, ties, short streams, window clamping, window change
// inside a stream), randomized streams with idle gaps and result stalls,
// and one stream at window 1 where every item selects. Checking is done by
// winnowing_pick_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module winnowing_fingerprint_select_tb;
    import wfs_pkg::*;

    localparam int                CYCLE_LIMIT  = 2_000_000;
    localparam int                RANDOM_ITEMS = 820;
    localparam int                LONG_STREAM  = 40;
    localparam int                SETTLE       = 16;
    localparam logic [HASH_W-1:0] HASH_TOP     = '1;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_we       = 1'b0;
    logic [WSZ_W-1:0]  cfg_wdata    = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [HASH_W-1:0] s_hash_value = '0;
    logic [LINE_W-1:0] s_start_line = '0;
    logic [LINE_W-1:0] s_end_line   = '0;
    logic              s_stream_end = 1'b0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [HASH_W-1:0] m_picked_hash;
    logic [LINE_W-1:0] m_picked_start_line;
    logic [LINE_W-1:0] m_picked_end_line;
    logic [CNT_W-1:0]  m_selection_count;

    int          fail_count;
    int          pending_count;
    int          results_checked;
    int          items_sent   = 0;
    int          streams_sent = 0;
    int          cycle_count  = 0;
    int          stall_left   = 0;
    bit          idle_on      = 1'b0;
    bit          stalls_on    = 1'b0;
    logic [15:0] sizes_written = '0;

    winnowing_fingerprint_select dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_hash_value        (s_hash_value),
        .s_start_line        (s_start_line),
        .s_end_line          (s_end_line),
        .s_stream_end        (s_stream_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_picked_hash       (m_picked_hash),
        .m_picked_start_line (m_picked_start_line),
        .m_picked_end_line   (m_picked_end_line),
        .m_selection_count   (m_selection_count)
    );

    winnowing_pick_checker u_pick_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_hash_value        (s_hash_value),
        .s_start_line        (s_start_line),
        .s_end_line          (s_end_line),
        .s_stream_end        (s_stream_end),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_picked_hash       (m_picked_hash),
        .m_picked_start_line (m_picked_start_line),
        .m_picked_end_line   (m_picked_end_line),
        .m_selection_count   (m_selection_count),
        .fail_count          (fail_count),
        .pending_count       (pending_count),
        .results_checked     (results_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [HASH_W-1:0] draw_hash();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       return HASH_W'($urandom_range(0, 15));
            1:       return HASH_W'($urandom_range(0, 1000));
            2:       return raw[0] ? HASH_TOP : '0;
            default: return raw[HASH_W-1:0];
        endcase
    endfunction

    function automatic logic [LINE_W-1:0] draw_line();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return LINE_W'($urandom);
        endcase
    endfunction

    // 0 and above-max settings show up now and then
    function automatic logic [WSZ_W-1:0] draw_window();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return WSZ_W'($urandom_range(WINDOW_MAX + 1, 15));
        return WSZ_W'($urandom_range(1, WINDOW_MAX));
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            m_ready    = 1'b0;
            stall_left = pick_gap();
        end else begin
            m_ready = 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_kgram(logic [HASH_W-1:0] h, logic [LINE_W-1:0] fl,
                              logic [LINE_W-1:0] ll, logic last);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_hash_value = h;
        s_start_line = fl;
        s_end_line   = ll;
        s_stream_end = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        if (last) streams_sent++;
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic set_window(logic [WSZ_W-1:0] v);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        sizes_written[v] = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    initial begin
        int base;
        int len;
        int turn;
        int r;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // default window of 4: extremes, tie goes to the newest
        idle_on   = 1'b1;
        stalls_on = 1'b1;
        push_kgram(HASH_TOP, 16'h0000, 16'hFFFF, 1'b0);
        push_kgram(HASH_TOP, 16'hFFFF, 16'h0000, 1'b0);
        push_kgram(63'd100, 16'd1, 16'd2, 1'b0);
        push_kgram(63'd100, 16'd3, 16'd4, 1'b0);
        push_kgram(63'd100, 16'd5, 16'd6, 1'b0);
        push_kgram('0, 16'd7, 16'd8, 1'b0);
        push_kgram(63'd7, 16'd9, 16'd9, 1'b1);
        // streams shorter than the window
        push_kgram(63'd50, 16'd10, 16'd10, 1'b0);
        push_kgram(63'd20, 16'd11, 16'd11, 1'b0);
        push_kgram(63'd20, 16'd12, 16'd12, 1'b1);
        push_kgram(HASH_TOP, 16'hFFFF, 16'hFFFF, 1'b1);

        // zero clamps to 1
        set_window('0);
        push_kgram(HASH_TOP, 16'h0000, 16'h0000, 1'b0);
        push_kgram('0, 16'hFFFF, 16'hFFFF, 1'b0);
        push_kgram(HASH_TOP, 16'd1, 16'd1, 1'b1);

        // 15 clamps to the maximum, then shrink with the minimum outside
        set_window(4'd15);
        push_kgram(63'd1, 16'd20, 16'd21, 1'b0);
        push_kgram(63'd50, 16'd22, 16'd23, 1'b0);
        push_kgram(63'd60, 16'd24, 16'd25, 1'b0);
        push_kgram(63'd70, 16'd26, 16'd27, 1'b0);
        push_kgram(63'd80, 16'd28, 16'd29, 1'b0);
        push_kgram(63'd90, 16'd30, 16'd31, 1'b0);
        push_kgram(63'd95, 16'd32, 16'd33, 1'b0);
        push_kgram(63'd99, 16'd34, 16'd35, 1'b0);
        push_kgram(63'd100, 16'd36, 16'd37, 1'b0);
        set_window(4'd3);
        push_kgram(63'd110, 16'd38, 16'd39, 1'b0);
        push_kgram(63'd5, 16'd40, 16'd41, 1'b1);

        // randomized streams
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) set_window(draw_window());
            idle_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            if (r < 3) len = $urandom_range(1, 4);
            else if (r < 9) len = $urandom_range(5, 30);
            else len = $urandom_range(40, 120);
            turn = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : -1;
            for (int i = 0; i < len; i++) begin
                if (i == turn) set_window(draw_window());
                push_kgram(draw_hash(), draw_line(), draw_line(), i == len - 1);
            end
        end

        // every item selects at window 1, back to back
        set_window(4'd1);
        idle_on   = 1'b0;
        stalls_on = 1'b0;
        for (int i = 0; i < LONG_STREAM; i++)
            push_kgram(draw_hash(), draw_line(), draw_line(), i == LONG_STREAM - 1);

        wait_drained();
        $display("Sent %0d items in %0d streams, including one %0d-item stream at window 1",
                 items_sent, streams_sent, LONG_STREAM);
        $display("Checked %0d result items, %0d mismatches; window values written: %b",
                 results_checked, fail_count, sizes_written);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
